// ===== rtl/ted_pkg.sv =====
// Shared types, byte codes and command codes of the terminal escape decoder.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package ted_pkg;

   // Result run: one received byte causes at most this many commands
   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned COUNT_W     = 3;

   // Register file
   localparam int unsigned CSR_ADDR_W       = 3;
   localparam logic        REG_REVERSE_MASK = 1'b0;
   localparam logic [7:0]  MASK_RESET       = 8'h01;

   // Screen command codes
   typedef enum logic [4:0] {
      OP_NONE    = 5'd0,
      OP_GLYPH   = 5'd1,
      OP_BS      = 5'd2,
      OP_TAB     = 5'd3,
      OP_LF      = 5'd4,
      OP_CR      = 5'd5,
      OP_UP      = 5'd6,
      OP_HOME    = 5'd7,
      OP_PLACE   = 5'd8,
      OP_CLEAR   = 5'd9,
      OP_EOS     = 5'd10,
      OP_BOS     = 5'd11,
      OP_EOL     = 5'd12,
      OP_BOL     = 5'd13,
      OP_LINE    = 5'd14,
      OP_ATTR    = 5'd15,
      OP_FORWARD = 5'd16,
      OP_REPLY   = 5'd17
   } op_code_type;

   // Control bytes
   localparam logic [7:0] CHR_ESC  = 8'h1B;
   localparam logic [7:0] CHR_BIAS = 8'h20;
   localparam logic [7:0] CHR_DEL  = 8'h7F;
   localparam logic [7:0] CHR_BS   = 8'h08;
   localparam logic [7:0] CHR_HT   = 8'h09;
   localparam logic [7:0] CHR_LF   = 8'h0A;
   localparam logic [7:0] CHR_CR   = 8'h0D;

   // Letters that follow ESC
   localparam logic [7:0] ESC_UP      = 8'h41; // A
   localparam logic [7:0] ESC_DOWN    = 8'h42; // B
   localparam logic [7:0] ESC_RIGHT   = 8'h43; // C
   localparam logic [7:0] ESC_LEFT    = 8'h44; // D
   localparam logic [7:0] ESC_CLEAR   = 8'h45; // E
   localparam logic [7:0] ESC_HOME    = 8'h48; // H
   localparam logic [7:0] ESC_RINDEX  = 8'h49; // I
   localparam logic [7:0] ESC_EOS     = 8'h4A; // J
   localparam logic [7:0] ESC_EOL     = 8'h4B; // K
   localparam logic [7:0] ESC_ADDR    = 8'h59; // Y
   localparam logic [7:0] ESC_BOS     = 8'h62; // b
   localparam logic [7:0] ESC_SAVE    = 8'h6A; // j
   localparam logic [7:0] ESC_RESTORE = 8'h6B; // k
   localparam logic [7:0] ESC_LINE    = 8'h6C; // l
   localparam logic [7:0] ESC_REPORT  = 8'h6E; // n
   localparam logic [7:0] ESC_BOL     = 8'h6F; // o
   localparam logic [7:0] ESC_REV_ON  = 8'h70; // p
   localparam logic [7:0] ESC_REV_OFF = 8'h71; // q
   localparam logic [7:0] ESC_ANSI    = 8'h3C; // <
   localparam logic [7:0] ESC_RESET   = 8'h7A; // z

   // Parser phase, one-hot
   typedef enum logic [3:0] {
      PH_GROUND = 4'b0001,
      PH_ESC    = 4'b0010,
      PH_ROW    = 4'b0100,
      PH_COL    = 4'b1000
   } phase_type;

   typedef struct packed {
      op_code_type op_code;
      logic [7:0]  op_row;
      logic [7:0]  op_col;
      logic [7:0]  op_data;
   } result_type;

   typedef result_type [MAX_RESULTS-1:0] result_set_type;

   // All commands caused by one byte, slot 0 first
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      result_set_type     items;
   } run_type;

   function automatic result_type make_result(
      input op_code_type op,
      input logic [7:0]  row,
      input logic [7:0]  col,
      input logic [7:0]  data
   );
      result_type r;
      r.op_code = op;
      r.op_row  = row;
      r.op_col  = col;
      r.op_data = data;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ted_csr.sv =====
// APB-style register file: holds the reverse video attribute mask.
// Depends on ted_pkg.
`default_nettype none

module ted_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [ted_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                   pwdata,
   output logic      [31:0]                   prdata,
   output logic                               pready,
   output logic      [7:0]                    reverse_mask
);
   import ted_pkg::*;

   logic [7:0] mask_ff;
   logic [7:0] mask_in;
   logic       wr_hit;

   // register index is the word address; byte lanes are ignored
   assign wr_hit  = psel && penable && pwrite && (paddr[2] == REG_REVERSE_MASK);
   assign mask_in = wr_hit ? pwdata[7:0] : mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == REG_REVERSE_MASK) begin
         prdata = {24'd0, mask_ff};
      end
   end

   assign pready       = 1'b1;
   assign reverse_mask = mask_ff;

endmodule

`default_nettype wire

// ===== rtl/ted_parser.sv =====
// Escape sequence parser: state registers plus the single-pass decode of one
// byte into a run of up to four commands. Depends on ted_pkg.
`default_nettype none

module ted_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       rx_byte,
   input  wire logic [7:0]       cursor_row,
   input  wire logic [7:0]       cursor_col,
   input  wire logic [7:0]       current_attr,
   input  wire logic             inner_left_ansi,
   input  wire logic [7:0]       reverse_mask,
   output ted_pkg::run_type      run
);
   import ted_pkg::*;

   phase_type  phase_ff, phase_in;
   logic       ansi_ff, ansi_in;
   logic       saved_valid_ff, saved_valid_in;
   logic [7:0] saved_row_ff, saved_row_in;
   logic [7:0] saved_col_ff, saved_col_in;
   logic [7:0] pending_row_ff, pending_row_in;
   logic [7:0] unbiased;

   assign unbiased = rx_byte - CHR_BIAS;

   always_comb begin
      phase_in       = phase_ff;
      ansi_in        = ansi_ff;
      saved_valid_in = saved_valid_ff;
      saved_row_in   = saved_row_ff;
      saved_col_in   = saved_col_ff;
      pending_row_in = pending_row_ff;
      run.count      = '0;
      run.items      = '0;

      if (ansi_ff) begin
         run.items[0] = make_result(OP_FORWARD, 8'd0, 8'd0, rx_byte);
         run.count    = 3'd1;
         if (inner_left_ansi) begin
            ansi_in = 1'b0;
         end
      end else begin
         case (phase_ff)
            PH_GROUND: begin
               if (rx_byte == CHR_ESC) begin
                  phase_in = PH_ESC;
               end else if (rx_byte == CHR_BS) begin
                  run.items[0] = make_result(OP_BS, 8'd0, 8'd0, 8'd0);
                  run.count    = 3'd1;
               end else if (rx_byte == CHR_HT) begin
                  run.items[0] = make_result(OP_TAB, 8'd0, 8'd0, 8'd0);
                  run.count    = 3'd1;
               end else if (rx_byte == CHR_LF) begin
                  run.items[0] = make_result(OP_LF, 8'd0, 8'd0, 8'd0);
                  run.count    = 3'd1;
               end else if (rx_byte == CHR_CR) begin
                  run.items[0] = make_result(OP_CR, 8'd0, 8'd0, 8'd0);
                  run.count    = 3'd1;
               end else if (rx_byte >= CHR_BIAS && rx_byte != CHR_DEL) begin
                  // high half of the code page prints as its low seven bits
                  run.items[0] = make_result(OP_GLYPH, 8'd0, 8'd0, {1'b0, rx_byte[6:0]});
                  run.count    = 3'd1;
               end
            end
            PH_ESC: begin
               phase_in = PH_GROUND;
               case (rx_byte)
                  ESC_UP: begin
                     run.items[0] = make_result(OP_UP, 8'd0, 8'd0, 8'd0);
                     run.count    = 3'd1;
                  end
                  ESC_DOWN: begin
                     run.items[0] = make_result(OP_PLACE,
                        (cursor_row == 8'hFF) ? 8'hFF : cursor_row + 8'd1, cursor_col, 8'd0);
                     run.count    = 3'd1;
                  end
                  ESC_RIGHT: begin
                     run.items[0] = make_result(OP_PLACE, cursor_row,
                        (cursor_col == 8'hFF) ? 8'hFF : cursor_col + 8'd1, 8'd0);
                     run.count    = 3'd1;
                  end
                  ESC_LEFT: begin
                     run.items[0] = make_result(OP_PLACE, cursor_row,
                        (cursor_col == 8'd0) ? 8'd0 : cursor_col - 8'd1, 8'd0);
                     run.count    = 3'd1;
                  end
                  ESC_HOME: begin
                     run.items[0] = make_result(OP_HOME, 8'd0, 8'd0, 8'd0);
                     run.count    = 3'd1;
                  end
                  ESC_RINDEX: begin
                     if (cursor_row != 8'd0) begin
                        run.items[0] = make_result(OP_PLACE, cursor_row - 8'd1,
                                                   cursor_col, 8'd0);
                        run.count    = 3'd1;
                     end
                  end
                  ESC_ADDR: begin
                     phase_in = PH_ROW;
                  end
                  ESC_REPORT: begin
                     run.items[0] = make_result(OP_REPLY, 8'd0, 8'd0, CHR_ESC);
                     run.items[1] = make_result(OP_REPLY, 8'd0, 8'd0, ESC_ADDR);
                     run.items[2] = make_result(OP_REPLY, 8'd0, 8'd0, cursor_row + CHR_BIAS);
                     run.items[3] = make_result(OP_REPLY, 8'd0, 8'd0, cursor_col + CHR_BIAS);
                     run.count    = 3'd4;
                  end
                  ESC_SAVE: begin
                     saved_row_in   = cursor_row;
                     saved_col_in   = cursor_col;
                     saved_valid_in = 1'b1;
                  end
                  ESC_RESTORE: begin
                     if (saved_valid_ff) begin
                        run.items[0] = make_result(OP_PLACE, saved_row_ff, saved_col_ff, 8'd0);
                        run.count    = 3'd1;
                     end
                  end
                  ESC_CLEAR: begin
                     run.items[0] = make_result(OP_CLEAR, 8'd0, 8'd0, 8'd0);
                     run.count    = 3'd1;
                  end
                  ESC_EOS: begin
                     run.items[0] = make_result(OP_EOS, 8'd0, 8'd0, 8'd0);
                     run.count    = 3'd1;
                  end
                  ESC_BOS: begin
                     run.items[0] = make_result(OP_BOS, 8'd0, 8'd0, 8'd0);
                     run.count    = 3'd1;
                  end
                  ESC_EOL: begin
                     run.items[0] = make_result(OP_EOL, 8'd0, 8'd0, 8'd0);
                     run.count    = 3'd1;
                  end
                  ESC_BOL: begin
                     run.items[0] = make_result(OP_BOL, 8'd0, 8'd0, 8'd0);
                     run.count    = 3'd1;
                  end
                  ESC_LINE: begin
                     run.items[0] = make_result(OP_LINE, 8'd0, 8'd0, 8'd0);
                     run.count    = 3'd1;
                  end
                  ESC_REV_ON: begin
                     run.items[0] = make_result(OP_ATTR, 8'd0, 8'd0,
                                                current_attr | reverse_mask);
                     run.count    = 3'd1;
                  end
                  ESC_REV_OFF: begin
                     run.items[0] = make_result(OP_ATTR, 8'd0, 8'd0,
                                                current_attr & ~reverse_mask);
                     run.count    = 3'd1;
                  end
                  ESC_ANSI: begin
                     ansi_in = 1'b1;
                  end
                  ESC_RESET: begin
                     run.items[0]   = make_result(OP_CLEAR, 8'd0, 8'd0, 8'd0);
                     run.items[1]   = make_result(OP_ATTR, 8'd0, 8'd0, 8'd0);
                     run.count      = 3'd2;
                     saved_valid_in = 1'b0;
                  end
                  default: begin
                     // unknown letter: swallowed
                  end
               endcase
            end
            PH_ROW: begin
               pending_row_in = unbiased;
               phase_in       = PH_COL;
            end
            PH_COL: begin
               run.items[0] = make_result(OP_PLACE, pending_row_ff, unbiased, 8'd0);
               run.count    = 3'd1;
               phase_in     = PH_GROUND;
            end
            default: begin
               phase_in = PH_GROUND;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_GROUND;
         ansi_ff        <= 1'b0;
         saved_valid_ff <= 1'b0;
         pending_row_ff <= 8'd0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         ansi_ff        <= ansi_in;
         saved_valid_ff <= saved_valid_in;
         pending_row_ff <= pending_row_in;
      end
   end

   // payload: only read after a write
   always_ff @(posedge clock) begin
      if (accept) begin
         saved_row_ff   <= saved_row_in;
         saved_col_ff   <= saved_col_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ted_out_queue.sv =====
// Result register: holds the run of one byte and shifts it out one beat at
// a time. Depends on ted_pkg.
`default_nettype none

module ted_out_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire ted_pkg::run_type    run,
   input  wire logic                rsp_stall,
   output logic                     can_load,
   output logic                     rsp_valid,
   output logic                     rsp_last,
   output ted_pkg::result_type      head
);
   import ted_pkg::*;

   result_set_type     items_ff, items_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               fire;

   assign rsp_valid = (count_ff != '0);
   assign rsp_last  = (count_ff == 3'd1);
   assign fire      = rsp_valid && !rsp_stall;
   // free now, or freed by the last beat leaving this cycle
   assign can_load  = !rsp_valid || (rsp_last && !rsp_stall);
   assign head      = items_ff[0];

   always_comb begin
      count_in = count_ff;
      items_in = items_ff;
      if (load) begin
         count_in = run.count;
         items_in = run.items;
      end else if (fire) begin
         count_in = count_ff - 3'd1;
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            items_in[i] = items_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      items_ff <= items_in;
   end

endmodule

`default_nettype wire

// ===== rtl/terminal_escape_decoder_top.sv =====
// Top level of the terminal escape decoder: register file, parser and
// result register. Depends on ted_pkg, ted_csr, ted_parser, ted_out_queue.
//
//   channel   direction  handshake            beat contents
//   req_      in         req_valid/req_stall  rx_byte, cursor_row/col, current_attr,
//                                             inner_left_ansi
//   rsp_      out        rsp_valid/rsp_stall  op_code, op_row, op_col, op_data,
//                                             last_of_run
//   APB       in/out     psel/penable/pready  reverse_attr_mask at address 0
//
// Flow: a byte is decoded in the cycle it is accepted; its commands appear
//   on rsp_ from the next cycle, one beat per cycle while rsp_stall is low. A
//   byte with more than one command (the cursor report, ESC z) holds req_ off
//   until its last beat departs, since the result register holds one byte's run.
// Reset: synchronous, active high; parser returns to ground, pass-through off,
//   saved cursor forgotten, mask back to 1. No clearing pass.
// Stalls: rsp_stall freezes the head beat; req_stall is high while any beat
//   other than a departing last one is still held.
`default_nettype none

module terminal_escape_decoder_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [7:0]                    req_rx_byte,
   input  wire logic [7:0]                    req_cursor_row,
   input  wire logic [7:0]                    req_cursor_col,
   input  wire logic [7:0]                    req_current_attr,
   input  wire logic                          req_inner_left_ansi,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [4:0]                    rsp_op_code,
   output logic      [7:0]                    rsp_op_row,
   output logic      [7:0]                    rsp_op_col,
   output logic      [7:0]                    rsp_op_data,
   output logic                               rsp_last_of_run,
   // register port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [ted_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                   pwdata,
   output logic      [31:0]                   prdata,
   output logic                               pready
);
   import ted_pkg::*;

   logic [7:0] mask;
   logic       can_load;
   logic       req_accept;
   run_type    run;
   result_type head;

   assign req_accept = req_valid && can_load;
   assign req_stall  = !can_load;

   ted_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .reverse_mask (mask)
   );

   // decode happens on the accepted beat; state advances at the same edge
   ted_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_accept),
      .rx_byte         (req_rx_byte),
      .cursor_row      (req_cursor_row),
      .cursor_col      (req_cursor_col),
      .current_attr    (req_current_attr),
      .inner_left_ansi (req_inner_left_ansi),
      .reverse_mask    (mask),
      .run             (run)
   );

   // result register; last_of_run is the final beat of the held run
   ted_out_queue u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .run       (run),
      .rsp_stall (rsp_stall),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_last  (rsp_last_of_run),
      .head      (head)
   );

   assign rsp_op_code = head.op_code;
   assign rsp_op_row  = head.op_row;
   assign rsp_op_col  = head.op_col;
   assign rsp_op_data = head.op_data;

   // a new byte only enters when no unsent beat of the previous run remains
   a_accept_after_run : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (!rsp_valid || (rsp_last_of_run && !rsp_stall)))
      else $error("byte accepted over an unfinished run");

   // a run does not break off before its last beat
   a_run_continues : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_of_run) |=> rsp_valid)
      else $error("run ended without a last beat");

   // a held beat, last or not, blocks the input side
   a_held_last_blocks : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while result held");

   // empty output means the input side is open
   a_idle_open : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("stall with empty result register");

endmodule

`default_nettype wire

// ===== verif/tb_terminal_escape_decoder_top.sv =====
// Self-checking testbench for terminal_escape_decoder_top: queue-fed driver, stall bursts,
// APB mask writes with read-back, and an in-bench decoder that predicts every command beat.
// Depends on rtl/ted_pkg.sv and rtl/terminal_escape_decoder_top.sv.
`default_nettype none

module tb_terminal_escape_decoder_top;
   import ted_pkg::*;

   // Byte values that need a name here but have none in the package
   localparam logic [7:0] CHR_NUL     = 8'h00;
   localparam logic [7:0] ESC_UNKNOWN = 8'h46;  // F: consumed, no command
   localparam logic [CSR_ADDR_W-1:0] MASK_ADDR = {REG_REVERSE_MASK, 2'b00};

   // One host byte with the screen context that travels with it
   typedef struct {
      logic [7:0] rx;
      logic [7:0] row;
      logic [7:0] col;
      logic [7:0] attr;
      logic       left;
      bit         drain_first;  // hold this beat until every command has come back
   } host_beat_type;

   // One screen command as it should show up on rsp_
   typedef struct {
      op_code_type op;
      logic [7:0]  row;
      logic [7:0]  col;
      logic [7:0]  data;
      logic        last;
   } screen_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = '0;
   logic [7:0] req_cursor_row = '0;
   logic [7:0] req_cursor_col = '0;
   logic [7:0] req_current_attr = '0;
   logic       req_inner_left_ansi = 1'b0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [4:0] rsp_op_code;
   logic [7:0] rsp_op_row;
   logic [7:0] rsp_op_col;
   logic [7:0] rsp_op_data;
   logic       rsp_last_of_run;

   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   terminal_escape_decoder_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .req_cursor_row     (req_cursor_row),
      .req_cursor_col     (req_cursor_col),
      .req_current_attr   (req_current_attr),
      .req_inner_left_ansi(req_inner_left_ansi),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_op_code        (rsp_op_code),
      .rsp_op_row         (rsp_op_row),
      .rsp_op_col         (rsp_op_col),
      .rsp_op_data        (rsp_op_data),
      .rsp_last_of_run    (rsp_last_of_run),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // 20-unit clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Every ESC letter with a defined meaning
   logic [7:0] esc_letters [0:19] = '{
      ESC_UP, ESC_DOWN, ESC_RIGHT, ESC_LEFT, ESC_CLEAR, ESC_HOME, ESC_RINDEX,
      ESC_EOS, ESC_EOL, ESC_ADDR, ESC_BOS, ESC_SAVE, ESC_RESTORE, ESC_LINE,
      ESC_REPORT, ESC_BOL, ESC_REV_ON, ESC_REV_OFF, ESC_ANSI, ESC_RESET
   };
   logic [7:0] ground_ctrls [0:3] = '{CHR_BS, CHR_HT, CHR_LF, CHR_CR};

   // Stimulus and expectations
   host_beat_type  host_q [$];
   screen_cmd_type cmds_due [$];
   screen_cmd_type head_cmd;
   host_beat_type  next_beat;

   int unsigned bytes_queued  = 0;
   int unsigned bytes_taken   = 0;
   int unsigned cmds_checked  = 0;
   int unsigned mismatches    = 0;
   int unsigned mask_writes   = 0;
   int unsigned send_gap      = 0;
   int unsigned recv_gap      = 0;
   int unsigned gap_odds      = 4;     // an idle burst starts with chance 1/(gap_odds+1)
   bit          quiet_tail    = 1'b0;  // last stretch: no idling on either side
   bit          drain_next    = 1'b0;
   bit          req_beat_taken = 1'b0; // set at the edge that took the presented beat

   // Decoder mirror: parser phase, address row, saved cursor, pass-through, mask
   phase_type  dec_phase       = PH_GROUND;
   logic [7:0] dec_pending_row = '0;
   logic       dec_saved_valid = 1'b0;
   logic [7:0] dec_saved_row   = '0;
   logic [7:0] dec_saved_col   = '0;
   logic       dec_passthrough = 1'b0;
   logic [7:0] reverse_mask    = MASK_RESET;

   function automatic screen_cmd_type screen_cmd(input op_code_type op, input logic [7:0] row,
                                                 input logic [7:0] col, input logic [7:0] data);
      screen_cmd_type c;
      c.op   = op;
      c.row  = row;
      c.col  = col;
      c.data = data;
      c.last = 1'b0;
      return c;
   endfunction

   // Works out the commands one accepted host byte causes and queues them
   task automatic decode_host_byte(input logic [7:0] b, input logic [7:0] row,
                                   input logic [7:0] col, input logic [7:0] attr,
                                   input logic left);
      screen_cmd_type run [$];
      logic [7:0]     unbiased;
      unbiased = b - CHR_BIAS;
      if (dec_passthrough) begin
         // everything goes to the outer emulator; exit flag ends the mode afterwards
         run.push_back(screen_cmd(OP_FORWARD, 8'h00, 8'h00, b));
         if (left) dec_passthrough = 1'b0;
      end else begin
         case (dec_phase)
            PH_GROUND: begin
               if (b == CHR_ESC) dec_phase = PH_ESC;
               else if (b == CHR_BS) run.push_back(screen_cmd(OP_BS, 8'h00, 8'h00, 8'h00));
               else if (b == CHR_HT) run.push_back(screen_cmd(OP_TAB, 8'h00, 8'h00, 8'h00));
               else if (b == CHR_LF) run.push_back(screen_cmd(OP_LF, 8'h00, 8'h00, 8'h00));
               else if (b == CHR_CR) run.push_back(screen_cmd(OP_CR, 8'h00, 8'h00, 8'h00));
               else if (b >= CHR_BIAS && b != CHR_DEL)
                  run.push_back(screen_cmd(OP_GLYPH, 8'h00, 8'h00, b & 8'h7F));
            end
            PH_ESC: begin
               dec_phase = PH_GROUND;
               case (b)
                  ESC_UP:    run.push_back(screen_cmd(OP_UP, 8'h00, 8'h00, 8'h00));
                  ESC_DOWN:  run.push_back(screen_cmd(OP_PLACE,
                                (row == 8'hFF) ? 8'hFF : row + 8'd1, col, 8'h00));
                  ESC_RIGHT: run.push_back(screen_cmd(OP_PLACE, row,
                                (col == 8'hFF) ? 8'hFF : col + 8'd1, 8'h00));
                  ESC_LEFT:  run.push_back(screen_cmd(OP_PLACE, row,
                                (col == 8'h00) ? 8'h00 : col - 8'd1, 8'h00));
                  ESC_HOME:  run.push_back(screen_cmd(OP_HOME, 8'h00, 8'h00, 8'h00));
                  ESC_RINDEX: begin
                     if (row != 8'h00) run.push_back(screen_cmd(OP_PLACE, row - 8'd1, col, 8'h00));
                  end
                  ESC_ADDR:  dec_phase = PH_ROW;
                  ESC_REPORT: begin
                     run.push_back(screen_cmd(OP_REPLY, 8'h00, 8'h00, CHR_ESC));
                     run.push_back(screen_cmd(OP_REPLY, 8'h00, 8'h00, ESC_ADDR));
                     run.push_back(screen_cmd(OP_REPLY, 8'h00, 8'h00, row + CHR_BIAS));
                     run.push_back(screen_cmd(OP_REPLY, 8'h00, 8'h00, col + CHR_BIAS));
                  end
                  ESC_SAVE: begin
                     dec_saved_row   = row;
                     dec_saved_col   = col;
                     dec_saved_valid = 1'b1;
                  end
                  ESC_RESTORE: begin
                     if (dec_saved_valid)
                        run.push_back(screen_cmd(OP_PLACE, dec_saved_row, dec_saved_col, 8'h00));
                  end
                  ESC_CLEAR: run.push_back(screen_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00));
                  ESC_EOS:   run.push_back(screen_cmd(OP_EOS, 8'h00, 8'h00, 8'h00));
                  ESC_BOS:   run.push_back(screen_cmd(OP_BOS, 8'h00, 8'h00, 8'h00));
                  ESC_EOL:   run.push_back(screen_cmd(OP_EOL, 8'h00, 8'h00, 8'h00));
                  ESC_BOL:   run.push_back(screen_cmd(OP_BOL, 8'h00, 8'h00, 8'h00));
                  ESC_LINE:  run.push_back(screen_cmd(OP_LINE, 8'h00, 8'h00, 8'h00));
                  ESC_REV_ON:
                     run.push_back(screen_cmd(OP_ATTR, 8'h00, 8'h00, attr | reverse_mask));
                  ESC_REV_OFF:
                     run.push_back(screen_cmd(OP_ATTR, 8'h00, 8'h00, attr & ~reverse_mask));
                  ESC_ANSI:  dec_passthrough = 1'b1;
                  ESC_RESET: begin
                     run.push_back(screen_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00));
                     run.push_back(screen_cmd(OP_ATTR, 8'h00, 8'h00, 8'h00));
                     dec_saved_valid = 1'b0;
                  end
                  default: ;  // unknown letter: swallowed
               endcase
            end
            PH_ROW: begin
               dec_pending_row = unbiased;
               dec_phase       = PH_COL;
            end
            default: begin
               run.push_back(screen_cmd(OP_PLACE, dec_pending_row, unbiased, 8'h00));
               dec_phase = PH_GROUND;
            end
         endcase
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) cmds_due.push_back(run[i]);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("MISMATCH %s: got 0x%0h, want 0x%0h (command %0d, t=%0t)",
               what, got, want, cmds_checked, $time);
   endtask

   // Coordinates lean on the saturation edges
   function automatic logic [7:0] pick_coord();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_beat(input logic [7:0] b, input logic [7:0] row, input logic [7:0] col,
                             input logic [7:0] attr, input logic left);
      host_beat_type h;
      h.rx   = b;
      h.row  = row;
      h.col  = col;
      h.attr = attr;
      h.left = left;
      h.drain_first = drain_next || ($urandom_range(0, 59) == 0);
      drain_next = 1'b0;
      host_q.push_back(h);
      bytes_queued++;
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic left);
      queue_beat(b, pick_coord(), pick_coord(), 8'($urandom_range(0, 255)), left);
   endtask

   // One random sequence: mostly well-formed escapes, then plain bytes, broken escapes, noise
   task automatic queue_random_sequence();
      int unsigned pick;
      int unsigned n;
      logic [7:0]  letter;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         letter = esc_letters[$urandom_range(0, 19)];
         queue_byte(CHR_ESC, 1'($urandom_range(0, 1)));
         queue_byte(letter, 1'($urandom_range(0, 1)));
         if (letter == ESC_ADDR) begin
            queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else if (letter == ESC_ANSI) begin
            // a few forwarded bytes, then the emulator reports it has left
            n = $urandom_range(0, 5);
            repeat (n) queue_byte(8'($urandom_range(0, 255)), 1'b0);
            queue_byte(8'($urandom_range(0, 255)), 1'b1);
         end else if (letter == ESC_SAVE && $urandom_range(0, 1)) begin
            queue_byte(CHR_ESC, 1'($urandom_range(0, 1)));
            queue_byte(ESC_RESTORE, 1'($urandom_range(0, 1)));
         end
      end else if (pick < 80) begin
         case ($urandom_range(0, 5))
            0:       letter = ground_ctrls[$urandom_range(0, 3)];
            1, 2:    letter = 8'($urandom_range(32, 126));
            3:       letter = 8'($urandom_range(128, 255));
            4:       letter = 8'($urandom_range(0, 31));
            default: letter = CHR_DEL;
         endcase
         queue_byte(letter, 1'($urandom_range(0, 1)));
      end else if (pick < 92) begin
         // broken escape: any byte after ESC, or an address cut short
         queue_byte(CHR_ESC, 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 2) == 0) begin
            queue_byte(ESC_ADDR, 1'($urandom_range(0, 1)));
            queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else begin
            queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
      end else begin
         queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
   endtask

   // Idle point: everything sent, taken and answered, then a settling wait for the parser
   task automatic wait_idle();
      while (bytes_taken != bytes_queued || cmds_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // APB write of the reverse mask, then read it back
   task automatic write_reverse_mask(input logic [7:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= MASK_ADDR;
      pwdata  <= {24'h0, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      reverse_mask = value;
      mask_writes++;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] !== value) report_mismatch("mask read-back", prdata[7:0], value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Driver: a presented beat holds until taken; otherwise idle burst or next queued beat
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_beat_taken)) begin
         req_beat_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (host_q.size() == 0 || (host_q[0].drain_first && cmds_due.size() != 0)) begin
            req_valid <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, gap_odds) == 0) begin
            send_gap = $urandom_range(1, 16) - 1;
            req_valid <= 1'b0;
         end else begin
            next_beat = host_q.pop_front();
            req_valid           <= 1'b1;
            req_rx_byte         <= next_beat.rx;
            req_cursor_row      <= next_beat.row;
            req_cursor_col      <= next_beat.col;
            req_current_attr    <= next_beat.attr;
            req_inner_left_ansi <= next_beat.left;
         end
      end
   end

   // Receiver back-pressure in bursts of random length
   always @(negedge clock) begin
      if (recv_gap > 0) begin
         recv_gap--;
         rsp_stall <= 1'b1;
      end else if (!reset && !quiet_tail && $urandom_range(0, gap_odds) == 0) begin
         recv_gap = $urandom_range(1, 16) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: check the departing command beat first, then predict from the accepted byte
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (cmds_due.size() == 0) begin
               report_mismatch("command with none due, op_code", rsp_op_code, OP_NONE);
            end else begin
               head_cmd = cmds_due.pop_front();
               if (rsp_op_code !== head_cmd.op)
                  report_mismatch("op_code", rsp_op_code, head_cmd.op);
               if (rsp_op_row !== head_cmd.row)
                  report_mismatch("op_row", rsp_op_row, head_cmd.row);
               if (rsp_op_col !== head_cmd.col)
                  report_mismatch("op_col", rsp_op_col, head_cmd.col);
               if (rsp_op_data !== head_cmd.data)
                  report_mismatch("op_data", rsp_op_data, head_cmd.data);
               if (rsp_last_of_run !== head_cmd.last)
                  report_mismatch("last_of_run", rsp_last_of_run, head_cmd.last);
               cmds_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            decode_host_byte(req_rx_byte, req_cursor_row, req_cursor_col, req_current_attr,
                             req_inner_left_ansi);
            bytes_taken++;
            req_beat_taken = 1'b1;
         end
      end
   end

   // Run sequence
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes and the corner cases, mask at its reset value
      gap_odds = 4;
      queue_beat(8'h20, 8'h00, 8'h00, 8'h00, 1'b0);             // lowest glyph
      queue_beat(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);             // high byte keeps low seven bits
      queue_beat(CHR_DEL, 8'h10, 8'h10, 8'h10, 1'b0);           // DEL ignored
      queue_beat(CHR_NUL, 8'h10, 8'h10, 8'h10, 1'b0);           // other control ignored
      queue_beat(CHR_ESC, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_beat(ESC_DOWN, 8'hFF, 8'h05, 8'h00, 1'b0);          // down saturates at 255
      queue_beat(CHR_ESC, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_beat(ESC_RIGHT, 8'h05, 8'hFF, 8'h00, 1'b0);         // right saturates at 255
      queue_beat(CHR_ESC, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_beat(ESC_LEFT, 8'h07, 8'h00, 8'h00, 1'b0);          // left stays at column 0
      queue_beat(CHR_ESC, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_beat(ESC_RINDEX, 8'h00, 8'h09, 8'h00, 1'b0);        // reverse index on top row
      queue_beat(CHR_ESC, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_beat(ESC_RESTORE, 8'h03, 8'h04, 8'h00, 1'b0);       // restore with nothing saved
      queue_beat(CHR_ESC, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_beat(ESC_ADDR, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_beat(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);             // row byte below bias wraps
      queue_beat(8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_beat(CHR_ESC, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_beat(ESC_REPORT, 8'hFF, 8'hE0, 8'h00, 1'b0);        // report bytes wrap
      queue_beat(CHR_ESC, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_beat(ESC_REV_ON, 8'h00, 8'h00, 8'hFE, 1'b0);
      queue_beat(CHR_ESC, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_beat(ESC_RESET, 8'h00, 8'h00, 8'h00, 1'b0);         // clear, then attr 0
      queue_beat(CHR_ESC, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_beat(ESC_UNKNOWN, 8'h00, 8'h00, 8'h00, 1'b0);       // unknown letter swallowed
      queue_beat(CHR_ESC, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_beat(ESC_ANSI, 8'h00, 8'h00, 8'h00, 1'b0);          // into pass-through
      queue_beat(CHR_ESC, 8'h00, 8'h00, 8'h00, 1'b0);           // forwarded, not parsed
      queue_beat(8'hA5, 8'h00, 8'h00, 8'h00, 1'b1);             // forwarded, mode ends
      wait_idle();

      // Random, full mask, heavy idling
      write_reverse_mask(8'hFF);
      gap_odds = 2;
      while (bytes_queued < 100) queue_random_sequence();
      wait_idle();

      // Random, empty mask, light idling; opens with a drained start
      write_reverse_mask(8'h00);
      gap_odds = 15;
      drain_next = 1'b1;
      while (bytes_queued < 150) queue_random_sequence();
      wait_idle();

      // Random mask, then a closing stretch with no idling at all
      write_reverse_mask(8'($urandom_range(1, 254)));
      gap_odds = 6;
      while (bytes_queued < 185) queue_random_sequence();
      wait_idle();
      quiet_tail = 1'b1;
      send_gap   = 0;
      recv_gap   = 0;
      while (bytes_queued < 220) queue_random_sequence();
      wait_idle();

      $display("Covered %0d host bytes and %0d screen commands across %0d mask settings",
               bytes_taken, cmds_checked, mask_writes + 1);
      if (mismatches == 0) begin
         $display("PASS terminal_escape_decoder_top");
      end else begin
         $display("FAIL terminal_escape_decoder_top");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #4000000;
      $display("Watchdog expired: %0d bytes taken of %0d, %0d commands still due",
               bytes_taken, bytes_queued, cmds_due.size());
      $display("FAIL terminal_escape_decoder_top");
      $finish;
   end

endmodule

`default_nettype wire
